[hdl/twp_pkg.sv]
package twp_pkg;

	localparam int unsigned DATA_W = 32;
	localparam logic signed [DATA_W-1:0] PIVOT_RESET = 32'sd2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_P_RD,
		ST_P_CMP,
		ST_P_SW1,
		ST_P_SW2,
		ST_E_RD,
		ST_E_LD
	} state_t;

	// store read address source
	typedef enum logic [2:0] {
		RD_SCAN,
		RD_BELOW,
		RD_ABOVE_M1,
		RD_EMIT,
		RD_EMIT_NXT
	} rd_sel_t;

	// store write address and data source during a swap
	typedef enum logic {
		WR_SCAN,
		WR_PARTNER
	} wr_sel_t;

	typedef struct packed {
		logic    store;       // write incoming item to the store
		logic    part_init;   // reset partition pointers
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cmp_cap;     // hold scanned item, compare result and partner
		logic    scan_inc;
		logic    below_inc;
		logic    above_dec;
		logic    wr_en;       // swap write
		wr_sel_t wr_sel;
		logic    emit_init;
		logic    emit_inc;
		logic    out_load;
		logic    emit_done;   // clear count and overflow for the next set
	} twp_cmd_t;

	typedef struct packed {
		logic scan_lt_above;
		logic cmp_lt;
		logic cmp_gt;
		logic lt_q;
		logic emit_last;
		logic out_free;
	} twp_sts_t;

endpackage

[hdl/twp_ctrl.sv]
module twp_ctrl
	import twp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tlast,
	output logic     s_tready,
	input  twp_sts_t sts,
	output twp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.store = 1'b1;
					if (s_tlast) begin
						cmd.part_init = 1'b1;
						state_d       = ST_P_RD;
					end
				end
			end
			ST_P_RD: begin
				if (sts.scan_lt_above) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SCAN;
					state_d    = ST_P_CMP;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = ST_E_RD;
				end
			end
			ST_P_CMP: begin
				cmd.cmp_cap = 1'b1;
				if (sts.cmp_lt) begin
					cmd.below_inc = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RD_BELOW;
					state_d       = ST_P_SW1;
				end else if (sts.cmp_gt) begin
					cmd.above_dec = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RD_ABOVE_M1;
					state_d       = ST_P_SW1;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d      = ST_P_RD;
				end
			end
			ST_P_SW1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SCAN;
				state_d    = ST_P_SW2;
			end
			ST_P_SW2: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WR_PARTNER;
				cmd.scan_inc = sts.lt_q;
				state_d      = ST_P_RD;
			end
			ST_E_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_EMIT;
				state_d    = ST_E_LD;
			end
			ST_E_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.emit_last) begin
						cmd.emit_done = 1'b1;
						state_d       = ST_LOAD;
					end else begin
						cmd.emit_inc = 1'b1;
						cmd.rd_en    = 1'b1;
						cmd.rd_sel   = RD_EMIT_NXT;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

[hdl/twp_dp.sv]
module twp_dp
	import twp_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DATA_W-1:0] s_tdata,
	input  logic              cfg_we,
	input  logic [DATA_W-1:0] cfg_wdata,
	input  twp_cmd_t          cmd,
	output twp_sts_t          sts,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] pivot_q;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] below_q;
	logic [CW-1:0] above_q;
	logic [CW-1:0] partner_q;
	logic [CW-1:0] k_q;
	logic          lt_q;

	logic          full;
	logic [CW-1:0] count_inc;
	logic [CW-1:0] above_m1;
	logic [CW-1:0] k_nxt;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic          wen;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_user_q;

	assign full      = (count_q == CW'(CAPACITY));
	assign count_inc = count_q + CW'(1);
	assign above_m1  = above_q - CW'(1);
	assign k_nxt     = k_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= PIVOT_RESET;
		end else if (cfg_we) begin
			pivot_q <= cfg_wdata;
		end
	end

	// store read port
	always_comb begin
		case (cmd.rd_sel)
			RD_SCAN:     raddr = scan_q[AW-1:0];
			RD_BELOW:    raddr = below_q[AW-1:0];
			RD_ABOVE_M1: raddr = above_m1[AW-1:0];
			RD_EMIT:     raddr = k_q[AW-1:0];
			RD_EMIT_NXT: raddr = k_nxt[AW-1:0];
			default:     raddr = scan_q[AW-1:0];
		endcase
	end

	// store write port: load or one half of a swap
	always_comb begin
		wen   = cmd.wr_en;
		waddr = partner_q[AW-1:0];
		wdata = x_q;
		if (cmd.store) begin
			wen   = !full;
			waddr = count_q[AW-1:0];
			wdata = s_tdata;
		end else if (cmd.wr_sel == WR_SCAN) begin
			waddr = scan_q[AW-1:0];
			wdata = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp_cap) begin
			x_q       <= rdata_q;
			partner_q <= sts.cmp_lt ? below_q : above_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			scan_q  <= '0;
			below_q <= '0;
			above_q <= '0;
			k_q     <= '0;
			lt_q    <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_inc;
				end
			end
			if (cmd.emit_done) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.part_init) begin
				scan_q  <= '0;
				below_q <= '0;
				above_q <= full ? count_q : count_inc;
			end
			if (cmd.cmp_cap) begin
				lt_q <= sts.cmp_lt;
			end
			if (cmd.scan_inc) begin
				scan_q <= scan_q + CW'(1);
			end
			if (cmd.below_inc) begin
				below_q <= below_q + CW'(1);
			end
			if (cmd.above_dec) begin
				above_q <= above_m1;
			end
			if (cmd.emit_init) begin
				k_q <= '0;
			end else if (cmd.emit_inc) begin
				k_q <= k_nxt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= rdata_q;
			out_last_q <= sts.emit_last;
			out_user_q <= ovf_q;
		end
	end

	assign sts.scan_lt_above = (scan_q < above_q);
	assign sts.cmp_lt        = ($signed(rdata_q) < pivot_q);
	assign sts.cmp_gt        = ($signed(rdata_q) > pivot_q);
	assign sts.lt_q          = lt_q;
	assign sts.emit_last     = (k_q == (count_q - CW'(1)));
	assign sts.out_free      = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

endmodule

[hdl/three_way_partition.sv]
// Three-way partition of a set of signed 32-bit values around a pivot.
// Input stream (s_*): one value per item, s_tlast on the final item of a set.
// Items are taken one per cycle into a store of CAPACITY entries; once the
// store is full further items are dropped and the set is flagged.
// On the last item the store is partitioned in place (below, equal, above the
// pivot) and then sent out in store order on the output stream (m_*), with
// m_tlast on the final value and m_tuser set on every value of a flagged set.
// Each partition step runs through the store: a value equal to the pivot is
// read and compared, and a value that is swapped is read, compared and
// written twice (read, compare, two writes). A final check of the scan
// pointer against the upper bound ends the partition. Output then reads and
// loads the first value, and moves one value per cycle after that while
// m_tready is held high. s_tready is low from the last item of a set until
// the final value of that set has been moved into the output register.
// A stalled receiver simply holds the output register and the emit sequencer;
// nothing is lost. The next set may load while the final value still waits.
// Reset (arst_n low) empties the store and clears the flag; the pivot returns
// to 2. cfg_we writes cfg_wdata to the pivot; write it only between sets.
module three_way_partition
	import twp_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic              s_tlast,
	input  logic              cfg_we,
	input  logic [DATA_W-1:0] cfg_wdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] value_res
	output logic              m_tlast,
	output logic              m_tuser    // [0] dropped
);

	twp_cmd_t cmd;
	twp_sts_t sts;

	// sequencer: load, partition steps, emit
	twp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, pointers, pivot and output register
	twp_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// never overwrite a value still waiting at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten while stalled");

	// a last item closes the input; it reopens once the set's final value is in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken during partition");

	// a swap write must follow a compare that chose a swap
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_sel == WR_SCAN) |-> $past(cmd.below_inc || cmd.above_dec))
		else $error("swap without a preceding compare");

endmodule
